/* src/lci_pkg.sv */
// shared widths, types and helpers for the line / circle intersection core
package lci_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned N_W        = 64;
  localparam int unsigned SUM_W      = 66;
  localparam int unsigned WIDE_W     = 128;
  localparam int unsigned MID_W      = 96;
  localparam int unsigned D_W        = 126;
  localparam int unsigned ROOT_W     = 63;
  localparam int unsigned SREM_W     = 65;
  localparam int unsigned NUM_W      = 98;
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CNT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned SQRT_CELLS = ROOT_W;
  localparam int unsigned DIV_CELLS  = QUO_W;
  localparam int unsigned LANES      = 4;

  // front stages, sqrt chain, product/numerator stages, divider chain, saturate, output
  localparam int unsigned PIPE_DEPTH = 6 + SQRT_CELLS + 4 + DIV_CELLS + 2;

  localparam int unsigned LANE_P1X = 0;
  localparam int unsigned LANE_P1Y = 1;
  localparam int unsigned LANE_P2X = 2;
  localparam int unsigned LANE_P2Y = 3;

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  localparam logic [CNT_W-1:0] CNT_NONE    = 2'd0;
  localparam logic [CNT_W-1:0] CNT_TANGENT = 2'd1;
  localparam logic [CNT_W-1:0] CNT_SECANT  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               ok;
    logic [CNT_W-1:0]   count;
    logic [N_W-1:0]     n;
    logic [NUM_W-1:0]   bx;
    logic [NUM_W-1:0]   by;
    logic               a_neg;
    logic               b_neg;
    logic [COORD_W-1:0] am;
    logic [COORD_W-1:0] bm;
  } geom_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
    logic [N_W-1:0]   n;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] big;
  } dside_t;

  function automatic logic [COORD_W-1:0] abs32(input logic [COORD_W-1:0] v);
    return v[COORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [PROD_W-1:0] mul32(input logic [HALF_W-1:0] x,
                                              input logic [HALF_W-1:0] y);
    return PROD_W'(x) * PROD_W'(y);
  endfunction

endpackage

/* src/line_circle_intersect_core.sv */
// throughput: one line per cycle; busy is low except right after reset
// the depth is set by the 63-cell square root chain and the 32-cell divider chains
// reset clears the valid pipe and the circle registers (centre 0, radius 0)
// each result is shown for one cycle only; the receiver cannot stall the core
module line_circle_intersect_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [lci_pkg::COORD_W-1:0]      in_line_a,
  input  logic signed [lci_pkg::COORD_W-1:0]      in_line_b,
  input  logic signed [lci_pkg::COORD_W-1:0]      in_line_c,
  output logic                                    out_valid,
  output logic        [lci_pkg::CNT_W-1:0]        out_hit_count,
  output logic signed [lci_pkg::COORD_W-1:0]      out_point1_x,
  output logic signed [lci_pkg::COORD_W-1:0]      out_point1_y,
  output logic signed [lci_pkg::COORD_W-1:0]      out_point2_x,
  output logic signed [lci_pkg::COORD_W-1:0]      out_point2_y,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [lci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [lci_pkg::COORD_W-1:0]      cfg_wdata
);
  import lci_pkg::*;

  // control and configuration
  logic                  busy_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  accept;
  logic [COORD_W-1:0]    cx_r;
  logic [COORD_W-1:0]    cy_r;
  logic [RAD_W-1:0]      rad_r;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      rad_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PIPE_DEPTH-2:0], accept};
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X: cx_r  <= cfg_wdata;
          REG_CENTER_Y: cy_r  <= cfg_wdata;
          REG_RADIUS:   rad_r <= cfg_wdata[RAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  logic [COORD_W-1:0] am, bm, xm, ym;
  assign am = abs32(in_line_a);
  assign bm = abs32(in_line_b);
  assign xm = abs32(cx_r);
  assign ym = abs32(cy_r);

  // stage 1: magnitude products
  logic [PROD_W-1:0]  s1_aa_r, s1_bb_r, s1_ax_r, s1_by_r, s1_rsq_r;
  logic               s1_axneg_r, s1_byneg_r, s1_a_neg_r, s1_b_neg_r;
  logic [COORD_W-1:0] s1_c_r, s1_am_r, s1_bm_r;

  always_ff @(posedge clk) begin
    s1_aa_r    <= mul32(am, am);
    s1_bb_r    <= mul32(bm, bm);
    s1_ax_r    <= mul32(am, xm);
    s1_by_r    <= mul32(bm, ym);
    s1_rsq_r   <= mul32({1'b0, rad_r}, {1'b0, rad_r});
    s1_axneg_r <= in_line_a[COORD_W-1] ^ cx_r[COORD_W-1];
    s1_byneg_r <= in_line_b[COORD_W-1] ^ cy_r[COORD_W-1];
    s1_a_neg_r <= in_line_a[COORD_W-1];
    s1_b_neg_r <= in_line_b[COORD_W-1];
    s1_c_r     <= in_line_c;
    s1_am_r    <= am;
    s1_bm_r    <= bm;
  end

  // stage 2: n = a*a + b*b, line value at the centre
  logic [SUM_W-1:0]   ax_s, by_s, c_s;
  logic [SUM_W-1:0]   s2_s_r;
  logic [N_W-1:0]     s2_n_r;
  logic [PROD_W-1:0]  s2_rsq_r;
  logic               s2_a_neg_r, s2_b_neg_r;
  logic [COORD_W-1:0] s2_am_r, s2_bm_r;

  always_comb begin
    ax_s = s1_axneg_r ? ('0 - {2'b00, s1_ax_r}) : {2'b00, s1_ax_r};
    by_s = s1_byneg_r ? ('0 - {2'b00, s1_by_r}) : {2'b00, s1_by_r};
    c_s  = {{(SUM_W-COORD_W-FRAC_W){s1_c_r[COORD_W-1]}}, s1_c_r, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    s2_s_r     <= ax_s + by_s + c_s;
    s2_n_r     <= s1_aa_r + s1_bb_r;
    s2_rsq_r   <= s1_rsq_r;
    s2_a_neg_r <= s1_a_neg_r;
    s2_b_neg_r <= s1_b_neg_r;
    s2_am_r    <= s1_am_r;
    s2_bm_r    <= s1_bm_r;
  end

  // stage 3: magnitude of the line value
  logic [SUM_W-1:0]   smag;
  logic [PROD_W-1:0]  s3_sm_r, s3_rsq_r;
  logic [N_W-1:0]     s3_n_r;
  logic               s3_nz_r, s3_asneg_r, s3_bsneg_r, s3_a_neg_r, s3_b_neg_r;
  logic [COORD_W-1:0] s3_am_r, s3_bm_r;

  assign smag = s2_s_r[SUM_W-1] ? ('0 - s2_s_r) : s2_s_r;

  always_ff @(posedge clk) begin
    s3_sm_r    <= smag[PROD_W-1:0];
    s3_rsq_r   <= s2_rsq_r;
    s3_n_r     <= s2_n_r;
    s3_nz_r    <= (s2_n_r != '0);
    s3_asneg_r <= s2_a_neg_r ^ s2_s_r[SUM_W-1];
    s3_bsneg_r <= s2_b_neg_r ^ s2_s_r[SUM_W-1];
    s3_a_neg_r <= s2_a_neg_r;
    s3_b_neg_r <= s2_b_neg_r;
    s3_am_r    <= s2_am_r;
    s3_bm_r    <= s2_bm_r;
  end

  // stage 4: 32x32 partial products of the wide terms
  logic [PROD_W-1:0]  s4_rr00_r, s4_rr01_r, s4_rr10_r, s4_rr11_r;
  logic [PROD_W-1:0]  s4_ss00_r, s4_ss01_r, s4_ss11_r;
  logic [PROD_W-1:0]  s4_xn0_r, s4_xn1_r, s4_yn0_r, s4_yn1_r;
  logic [PROD_W-1:0]  s4_as0_r, s4_as1_r, s4_bs0_r, s4_bs1_r;
  logic [N_W-1:0]     s4_n_r;
  logic               s4_nz_r, s4_asneg_r, s4_bsneg_r, s4_a_neg_r, s4_b_neg_r;
  logic [COORD_W-1:0] s4_am_r, s4_bm_r;

  always_ff @(posedge clk) begin
    s4_rr00_r  <= mul32(s3_rsq_r[HALF_W-1:0], s3_n_r[HALF_W-1:0]);
    s4_rr01_r  <= mul32(s3_rsq_r[HALF_W-1:0], s3_n_r[N_W-1:HALF_W]);
    s4_rr10_r  <= mul32(s3_rsq_r[PROD_W-1:HALF_W], s3_n_r[HALF_W-1:0]);
    s4_rr11_r  <= mul32(s3_rsq_r[PROD_W-1:HALF_W], s3_n_r[N_W-1:HALF_W]);
    s4_ss00_r  <= mul32(s3_sm_r[HALF_W-1:0], s3_sm_r[HALF_W-1:0]);
    s4_ss01_r  <= mul32(s3_sm_r[HALF_W-1:0], s3_sm_r[PROD_W-1:HALF_W]);
    s4_ss11_r  <= mul32(s3_sm_r[PROD_W-1:HALF_W], s3_sm_r[PROD_W-1:HALF_W]);
    s4_xn0_r   <= mul32(xm, s3_n_r[HALF_W-1:0]);
    s4_xn1_r   <= mul32(xm, s3_n_r[N_W-1:HALF_W]);
    s4_yn0_r   <= mul32(ym, s3_n_r[HALF_W-1:0]);
    s4_yn1_r   <= mul32(ym, s3_n_r[N_W-1:HALF_W]);
    s4_as0_r   <= mul32(s3_am_r, s3_sm_r[HALF_W-1:0]);
    s4_as1_r   <= mul32(s3_am_r, s3_sm_r[PROD_W-1:HALF_W]);
    s4_bs0_r   <= mul32(s3_bm_r, s3_sm_r[HALF_W-1:0]);
    s4_bs1_r   <= mul32(s3_bm_r, s3_sm_r[PROD_W-1:HALF_W]);
    s4_n_r     <= s3_n_r;
    s4_nz_r    <= s3_nz_r;
    s4_asneg_r <= s3_asneg_r;
    s4_bsneg_r <= s3_bsneg_r;
    s4_a_neg_r <= s3_a_neg_r;
    s4_b_neg_r <= s3_b_neg_r;
    s4_am_r    <= s3_am_r;
    s4_bm_r    <= s3_bm_r;
  end

  // stage 5: sum the partial products
  logic [WIDE_W-1:0]  s5_rr_r, s5_ss_r;
  logic [MID_W-1:0]   s5_xn_r, s5_yn_r, s5_as_r, s5_bs_r;
  logic [N_W-1:0]     s5_n_r;
  logic               s5_nz_r, s5_asneg_r, s5_bsneg_r, s5_a_neg_r, s5_b_neg_r;
  logic [COORD_W-1:0] s5_am_r, s5_bm_r;

  always_ff @(posedge clk) begin
    s5_rr_r    <= {64'b0, s4_rr00_r} + {32'b0, s4_rr01_r, 32'b0}
                + {32'b0, s4_rr10_r, 32'b0} + {s4_rr11_r, 64'b0};
    s5_ss_r    <= {64'b0, s4_ss00_r} + {31'b0, s4_ss01_r, 33'b0} + {s4_ss11_r, 64'b0};
    s5_xn_r    <= {32'b0, s4_xn0_r} + {s4_xn1_r, 32'b0};
    s5_yn_r    <= {32'b0, s4_yn0_r} + {s4_yn1_r, 32'b0};
    s5_as_r    <= {32'b0, s4_as0_r} + {s4_as1_r, 32'b0};
    s5_bs_r    <= {32'b0, s4_bs0_r} + {s4_bs1_r, 32'b0};
    s5_n_r     <= s4_n_r;
    s5_nz_r    <= s4_nz_r;
    s5_asneg_r <= s4_asneg_r;
    s5_bsneg_r <= s4_bsneg_r;
    s5_a_neg_r <= s4_a_neg_r;
    s5_b_neg_r <= s4_b_neg_r;
    s5_am_r    <= s4_am_r;
    s5_bm_r    <= s4_bm_r;
  end

  // stage 6: discriminant, foot point numerators
  logic [WIDE_W-1:0] dfull;
  logic [NUM_W-1:0]  xs, ys, as_s, bs_s;
  geom_t             g6;
  logic [D_W-1:0]    s6_d_r;
  geom_t             gside_r [0:SQRT_CELLS];

  always_comb begin
    dfull    = s5_rr_r - s5_ss_r;
    xs       = cx_r[COORD_W-1] ? ('0 - {2'b00, s5_xn_r}) : {2'b00, s5_xn_r};
    ys       = cy_r[COORD_W-1] ? ('0 - {2'b00, s5_yn_r}) : {2'b00, s5_yn_r};
    as_s     = s5_asneg_r ? ('0 - {2'b00, s5_as_r}) : {2'b00, s5_as_r};
    bs_s     = s5_bsneg_r ? ('0 - {2'b00, s5_bs_r}) : {2'b00, s5_bs_r};
    g6.ok    = s5_nz_r && (s5_rr_r >= s5_ss_r);
    g6.count = (s5_rr_r == s5_ss_r) ? CNT_TANGENT : CNT_SECANT;
    g6.n     = s5_n_r;
    g6.bx    = xs - as_s;
    g6.by    = ys - bs_s;
    g6.a_neg = s5_a_neg_r;
    g6.b_neg = s5_b_neg_r;
    g6.am    = s5_am_r;
    g6.bm    = s5_bm_r;
  end

  always_ff @(posedge clk) begin
    s6_d_r     <= dfull[D_W-1:0];
    gside_r[0] <= g6;
    for (int i = 1; i <= SQRT_CELLS; i++) begin
      gside_r[i] <= gside_r[i-1];
    end
  end

  // square root chain, one result bit per cell
  logic [D_W-1:0]    sq_d    [0:SQRT_CELLS];
  logic [SREM_W-1:0] sq_rem  [0:SQRT_CELLS];
  logic [ROOT_W-1:0] sq_root [0:SQRT_CELLS];

  assign sq_d[0]    = s6_d_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    lci_sqrt_cell #(.PAIR(SQRT_CELLS-1-i)) u_cell (
      .clk      (clk),
      .d_in     (sq_d[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .d_out    (sq_d[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  // t1: offsets along the line, partial products with the root
  geom_t             gq;
  logic [ROOT_W-1:0] q;
  logic [PROD_W-1:0] t1_bq0_r, t1_bq1_r, t1_aq0_r, t1_aq1_r;
  geom_t             t1_g_r, t2_g_r, t3_g_r;
  logic [MID_W-1:0]  t2_tx_r, t2_ty_r;

  assign gq = gside_r[SQRT_CELLS];
  assign q  = sq_root[SQRT_CELLS];

  always_ff @(posedge clk) begin
    t1_bq0_r <= mul32(gq.bm, q[HALF_W-1:0]);
    t1_bq1_r <= mul32(gq.bm, {1'b0, q[ROOT_W-1:HALF_W]});
    t1_aq0_r <= mul32(gq.am, q[HALF_W-1:0]);
    t1_aq1_r <= mul32(gq.am, {1'b0, q[ROOT_W-1:HALF_W]});
    t1_g_r   <= gq;
    t2_tx_r  <= {32'b0, t1_bq0_r} + {t1_bq1_r, 32'b0};
    t2_ty_r  <= {32'b0, t1_aq0_r} + {t1_aq1_r, 32'b0};
    t2_g_r   <= t1_g_r;
  end

  // t3: the four point numerators
  logic [NUM_W-1:0] txs, tys;
  logic [NUM_W-1:0] t3_num_r [0:LANES-1];

  assign txs = t2_g_r.b_neg ? ('0 - {2'b00, t2_tx_r}) : {2'b00, t2_tx_r};
  assign tys = t2_g_r.a_neg ? ('0 - {2'b00, t2_ty_r}) : {2'b00, t2_ty_r};

  always_ff @(posedge clk) begin
    t3_num_r[LANE_P1X] <= t2_g_r.bx - txs;
    t3_num_r[LANE_P1Y] <= t2_g_r.by + tys;
    t3_num_r[LANE_P2X] <= t2_g_r.bx + txs;
    t3_num_r[LANE_P2Y] <= t2_g_r.by - tys;
    t3_g_r             <= t2_g_r;
  end

  // t4: magnitudes, overflow check against n * 2^32, divider start values
  logic [NUM_W-1:0]  mag    [0:LANES-1];
  dside_t            d4;
  logic [N_W-1:0]    t4_rem_r [0:LANES-1];
  logic [QUO_W-1:0]  t4_lo_r  [0:LANES-1];
  dside_t            dside_r  [0:DIV_CELLS];

  always_comb begin
    d4.ok    = t3_g_r.ok;
    d4.count = t3_g_r.count;
    d4.n     = t3_g_r.n;
    for (int l = 0; l < LANES; l++) begin
      d4.neg[l] = t3_num_r[l][NUM_W-1];
      mag[l]    = d4.neg[l] ? ('0 - t3_num_r[l]) : t3_num_r[l];
      // quotient of 2^32 or more saturates either way
      d4.big[l] = (mag[l] >= {2'b00, t3_g_r.n, 32'b0});
    end
  end

  always_ff @(posedge clk) begin
    dside_r[0] <= d4;
    for (int l = 0; l < LANES; l++) begin
      t4_rem_r[l] <= mag[l][MID_W-1:QUO_W];
      t4_lo_r[l]  <= mag[l][QUO_W-1:0];
    end
    for (int i = 1; i <= DIV_CELLS; i++) begin
      dside_r[i] <= dside_r[i-1];
    end
  end

  // divider chains, one lane per coordinate
  logic [N_W-1:0]   dv_rem [0:LANES-1][0:DIV_CELLS];
  logic [QUO_W-1:0] dv_lo  [0:LANES-1][0:DIV_CELLS];
  logic [QUO_W-1:0] dv_quo [0:LANES-1][0:DIV_CELLS];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign dv_rem[l][0] = t4_rem_r[l];
    assign dv_lo[l][0]  = t4_lo_r[l];
    assign dv_quo[l][0] = '0;
    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      lci_div_cell #(.BIT(DIV_CELLS-1-i)) u_cell (
        .clk     (clk),
        .den     (dside_r[i].n),
        .rem_in  (dv_rem[l][i]),
        .lo_in   (dv_lo[l][i]),
        .quo_in  (dv_quo[l][i]),
        .rem_out (dv_rem[l][i+1]),
        .lo_out  (dv_lo[l][i+1]),
        .quo_out (dv_quo[l][i+1])
      );
    end
  end

  // f1: sign and saturate
  dside_t             dq;
  logic [COORD_W-1:0] sat [0:LANES-1];
  logic [COORD_W-1:0] f1_pt_r [0:LANES-1];
  logic               f1_ok_r;
  logic [CNT_W-1:0]   f1_count_r;

  assign dq = dside_r[DIV_CELLS];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dq.neg[l]) begin
        sat[l] = (dq.big[l] || (dv_quo[l][DIV_CELLS] > SAT_MIN)) ? SAT_MIN
               : ('0 - dv_quo[l][DIV_CELLS]);
      end else begin
        sat[l] = (dq.big[l] || dv_quo[l][DIV_CELLS][QUO_W-1]) ? SAT_MAX
               : dv_quo[l][DIV_CELLS];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      f1_pt_r[l] <= sat[l];
    end
    f1_ok_r    <= dq.ok;
    f1_count_r <= dq.count;
  end

  // output register: order the points, blank unused fields
  logic               swap;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [COORD_W-1:0] p1x_nxt, p1y_nxt, p2x_nxt, p2y_nxt;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [COORD_W-1:0] out_p1x_r, out_p1y_r, out_p2x_r, out_p2y_r;

  always_comb begin
    swap = ($signed(f1_pt_r[LANE_P2Y]) > $signed(f1_pt_r[LANE_P1Y]))
        || ((f1_pt_r[LANE_P2Y] == f1_pt_r[LANE_P1Y])
            && ($signed(f1_pt_r[LANE_P2X]) > $signed(f1_pt_r[LANE_P1X])));
    cnt_nxt = CNT_NONE;
    p1x_nxt = '0;
    p1y_nxt = '0;
    p2x_nxt = '0;
    p2y_nxt = '0;
    if (f1_ok_r) begin
      cnt_nxt = f1_count_r;
      p1x_nxt = swap ? f1_pt_r[LANE_P2X] : f1_pt_r[LANE_P1X];
      p1y_nxt = swap ? f1_pt_r[LANE_P2Y] : f1_pt_r[LANE_P1Y];
      if (f1_count_r == CNT_SECANT) begin
        p2x_nxt = swap ? f1_pt_r[LANE_P1X] : f1_pt_r[LANE_P2X];
        p2y_nxt = swap ? f1_pt_r[LANE_P1Y] : f1_pt_r[LANE_P2Y];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_cnt_r <= cnt_nxt;
    out_p1x_r <= p1x_nxt;
    out_p1y_r <= p1y_nxt;
    out_p2x_r <= p2x_nxt;
    out_p2y_r <= p2y_nxt;
  end

  assign out_valid     = vld_r[PIPE_DEPTH-1];
  assign out_hit_count = out_cnt_r;
  assign out_point1_x  = out_p1x_r;
  assign out_point1_y  = out_p1y_r;
  assign out_point2_x  = out_p2x_r;
  assign out_point2_y  = out_p2y_r;

  // every accepted transaction comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_valid)
    else $error("result missing at pipeline depth");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_count == CNT_NONE) || (out_hit_count == CNT_TANGENT)
                  || (out_hit_count == CNT_SECANT))
    else $error("hit count out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_count == CNT_NONE) |->
      (out_point1_x == '0) && (out_point1_y == '0)
      && (out_point2_x == '0) && (out_point2_y == '0))
    else $error("miss with nonzero points");

  a_tangent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_count == CNT_TANGENT) |->
      (out_point2_x == '0) && (out_point2_y == '0))
    else $error("tangent with nonzero second point");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_count == CNT_SECANT) |->
      ($signed(out_point1_y) > $signed(out_point2_y))
      || ((out_point1_y == out_point2_y) && ($signed(out_point1_x) >= $signed(out_point2_x))))
    else $error("secant points out of order");

endmodule

/* src/lci_sqrt_cell.sv */
// one digit step of the pipelined integer square root
module lci_sqrt_cell #(
  parameter int unsigned PAIR = 0
) (
  input  logic                         clk,
  input  logic [lci_pkg::D_W-1:0]      d_in,
  input  logic [lci_pkg::SREM_W-1:0]   rem_in,
  input  logic [lci_pkg::ROOT_W-1:0]   root_in,
  output logic [lci_pkg::D_W-1:0]      d_out,
  output logic [lci_pkg::SREM_W-1:0]   rem_out,
  output logic [lci_pkg::ROOT_W-1:0]   root_out
);
  import lci_pkg::*;

  logic [SREM_W+1:0] cur;
  logic [SREM_W+1:0] trial;
  logic [SREM_W+1:0] diff;
  logic              ge;
  logic [SREM_W-1:0] rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [D_W-1:0]    d_r;
  logic [SREM_W-1:0] rem_r;
  logic [ROOT_W-1:0] root_r;

  always_comb begin
    // bring down the next two radicand bits, try root*4+1
    cur      = {rem_in, d_in[2*PAIR+1 -: 2]};
    trial    = {{(SREM_W-ROOT_W){1'b0}}, root_in, 2'b01};
    diff     = cur - trial;
    ge       = (cur >= trial);
    rem_nxt  = ge ? diff[SREM_W-1:0] : cur[SREM_W-1:0];
    root_nxt = {root_in[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    d_r    <= d_in;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign d_out    = d_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

/* src/lci_div_cell.sv */
// one quotient bit of the pipelined restoring divider
module lci_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                        clk,
  input  logic [lci_pkg::N_W-1:0]     den,
  input  logic [lci_pkg::N_W-1:0]     rem_in,
  input  logic [lci_pkg::QUO_W-1:0]   lo_in,
  input  logic [lci_pkg::QUO_W-1:0]   quo_in,
  output logic [lci_pkg::N_W-1:0]     rem_out,
  output logic [lci_pkg::QUO_W-1:0]   lo_out,
  output logic [lci_pkg::QUO_W-1:0]   quo_out
);
  import lci_pkg::*;

  logic [N_W:0]     cur;
  logic [N_W:0]     dext;
  logic [N_W:0]     diff;
  logic             ge;
  logic [N_W-1:0]   rem_nxt;
  logic [QUO_W-1:0] quo_nxt;
  logic [N_W-1:0]   rem_r;
  logic [QUO_W-1:0] lo_r;
  logic [QUO_W-1:0] quo_r;

  always_comb begin
    cur      = {rem_in, lo_in[BIT]};
    dext     = {1'b0, den};
    diff     = cur - dext;
    ge       = (cur >= dext);
    rem_nxt  = ge ? diff[N_W-1:0] : cur[N_W-1:0];
    quo_nxt  = quo_in;
    quo_nxt[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_in;
    quo_r <= quo_nxt;
  end

  assign rem_out = rem_r;
  assign lo_out  = lo_r;
  assign quo_out = quo_r;

endmodule
